@@ rtl/core/cyk_pkg.sv @@
// Shared types and constants of the CYK membership recognizer.
package cyk_pkg;

  localparam int unsigned NtIdxW = 6;
  localparam int unsigned SymW   = 8;
  localparam int unsigned NumSym = 256;

  typedef enum logic [1:0] {
    ModeBinRule = 2'd0,
    ModeTermRule = 2'd1,
    ModeSymbol = 2'd2,
    ModeClear = 2'd3
  } cyk_mode_e;

  typedef enum logic [1:0] {
    StatusOk = 2'd0,
    StatusTooLong = 2'd1,
    StatusOverflow = 2'd2
  } cyk_status_e;

  typedef enum logic [3:0] {
    StIdle,
    StTerm,
    StDiagRd,
    StDiagSym,
    StDiagWr,
    StCellStart,
    StPairRd,
    StRuleRd,
    StRuleEv,
    StCellWr,
    StFinalRd,
    StFinalEv,
    StFinish
  } cyk_state_e;

  typedef struct packed {
    cyk_mode_e          mode;
    logic [NtIdxW-1:0]  head;
    logic [NtIdxW-1:0]  left_child;
    logic [NtIdxW-1:0]  right_child;
    logic [SymW-1:0]    symbol;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    cyk_status_e status;
  } out_word_t;

endpackage

@@ rtl/core/cyk_membership_recognizer.sv @@
// Top level of the CYK membership recognizer: rule stores, word store, chart and sequencer.
// Rule, terminal-rule, clear and plain symbol words are taken one per cycle while idle (a
// terminal rule stalls the next word while StTerm writes the mask read on intake). The
// word marked last starts the parse: the diagonal is filled symbol by symbol (read the
// symbol, read its terminal mask, write the cell), then for every chart cell (i, j) with
// any binary rule stored, each split point p gets one two-cell chart read and each rule a
// read and a test by the single rule-test unit that walks the rule memory. A result that
// needs no parse (word too long, rule table overflowed) goes straight to the finish state.
// No word is taken while a parse runs. No clearing pass is needed after reset.
module cyk_membership_recognizer #(
  parameter int unsigned MAX_WORD         = 128,
  parameter int unsigned NONTERMS         = 64,
  parameter int unsigned MAX_BINARY_RULES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cyk_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cyk_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i
);
  import cyk_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_WORD);
  localparam int unsigned LW  = $clog2(MAX_WORD + 1);
  localparam int unsigned NTW = (NONTERMS > 1) ? $clog2(NONTERMS) : 1;
  localparam int unsigned RAW = $clog2(MAX_BINARY_RULES);
  localparam int unsigned RCW = $clog2(MAX_BINARY_RULES + 1);
  localparam int unsigned RW  = 3 * NtIdxW;

  // storage
  logic [RW-1:0]       rule_mem  [MAX_BINARY_RULES];
  logic [NONTERMS-1:0] tmask_mem [NumSym];
  logic [SymW-1:0]     word_mem  [MAX_WORD];
  logic [NONTERMS-1:0] chart_mem [MAX_WORD][MAX_WORD];
  logic [NumSym-1:0]   tvalid_q;

  cyk_state_e state_q, state_d;

  logic [NtIdxW-1:0]   start_q;
  logic [RCW-1:0]      rcount_q;
  logic                ovf_q;
  logic [LW-1:0]       wlen_q;
  logic                too_long_q;
  logic [LW-1:0]       n_q;
  logic [LW-1:0]       len_q;
  logic [IW-1:0]       i_q;
  logic [IW-1:0]       p_q;
  logic [RCW-1:0]      r_q;
  logic [NONTERMS-1:0] acc_q;
  logic [NtIdxW-1:0]   thead_q;
  logic [SymW-1:0]     tsym_q;
  logic                res_acc_q;
  cyk_status_e         res_status_q;
  logic                out_valid_q;
  out_word_t           out_word_q;

  logic [RW-1:0]       rule_rd_q;
  logic [NONTERMS-1:0] tmask_rd_q;
  logic                tvalid_rd_q;
  logic [SymW-1:0]     word_rd_q;
  logic [NONTERMS-1:0] left_rd_q;
  logic [NONTERMS-1:0] right_rd_q;

  logic                in_acc;
  logic                rule_ok;
  logic                head_ok;
  logic [IW-1:0]       j_c;
  logic [IW-1:0]       p1_c;
  logic [LW:0]         i_end_c;
  logic [NONTERMS-1:0] hit_c;
  logic                out_free;
  logic [LW-1:0]       wlen_next;

  assign in_acc   = in_valid_i && (state_q == StIdle);
  assign head_ok  = {1'b0, in_word_i.head} < (NtIdxW + 1)'(NONTERMS);
  assign rule_ok  = head_ok
                 && ({1'b0, in_word_i.left_child} < (NtIdxW + 1)'(NONTERMS))
                 && ({1'b0, in_word_i.right_child} < (NtIdxW + 1)'(NONTERMS));
  assign j_c      = IW'(LW'(i_q) + len_q - LW'(1));
  assign p1_c     = p_q + IW'(1);
  assign i_end_c  = (LW + 1)'(i_q) + (LW + 1)'(len_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign wlen_next = (wlen_q < LW'(MAX_WORD)) ? wlen_q + LW'(1) : wlen_q;

  always_comb begin
    hit_c = '0;
    if (left_rd_q[rule_rd_q[NtIdxW+NTW-1:NtIdxW]] && right_rd_q[rule_rd_q[NTW-1:0]]) begin
      hit_c[rule_rd_q[2*NtIdxW+NTW-1:2*NtIdxW]] = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (in_word_i.mode)
            ModeTermRule: if (head_ok) state_d = StTerm;
            ModeSymbol: begin
              if (in_word_i.last) begin
                if (wlen_q == LW'(MAX_WORD) || too_long_q || ovf_q) state_d = StFinish;
                else state_d = StDiagRd;
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StTerm:    state_d = StIdle;
      StDiagRd:  state_d = StDiagSym;
      StDiagSym: state_d = StDiagWr;
      StDiagWr: begin
        if (LW'(i_q) == n_q - LW'(1)) begin
          state_d = (n_q == LW'(1)) ? StFinalRd : StCellStart;
        end else begin
          state_d = StDiagRd;
        end
      end
      StCellStart: state_d = (rcount_q == '0) ? StCellWr : StPairRd;
      StPairRd:    state_d = StRuleRd;
      StRuleRd:    state_d = StRuleEv;
      StRuleEv: begin
        if (r_q == rcount_q - RCW'(1)) begin
          state_d = (p1_c == j_c) ? StCellWr : StPairRd;
        end else begin
          state_d = StRuleRd;
        end
      end
      StCellWr: begin
        if (i_end_c == (LW + 1)'(n_q)) begin
          state_d = (len_q == n_q) ? StFinalRd : StCellStart;
        end else begin
          state_d = StCellStart;
        end
      end
      StFinalRd: state_d = StFinalEv;
      StFinalEv: state_d = StFinish;
      StFinish:  if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = (state_q != StIdle);
    out_valid_o = out_valid_q;
    out_word_o  = out_word_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      start_q    <= '0;
      rcount_q   <= '0;
      ovf_q      <= 1'b0;
      wlen_q     <= '0;
      too_long_q <= 1'b0;
      tvalid_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (state_q == StFinish && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == StTerm) tvalid_q[tsym_q] <= 1'b1;
      if (in_acc) begin
        unique case (in_word_i.mode)
          ModeBinRule: begin
            if (rule_ok) begin
              if (rcount_q < RCW'(MAX_BINARY_RULES)) rcount_q <= rcount_q + RCW'(1);
              else ovf_q <= 1'b1;
            end
          end
          ModeTermRule: ;
          ModeSymbol: begin
            if (in_word_i.last) begin
              wlen_q     <= '0;
              too_long_q <= 1'b0;
            end else begin
              wlen_q <= wlen_next;
              if (wlen_q == LW'(MAX_WORD)) too_long_q <= 1'b1;
            end
          end
          ModeClear: begin
            rcount_q <= '0;
            ovf_q    <= 1'b0;
            tvalid_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath and sequencer counters
  always_ff @(posedge clk_i) begin
    if (state_q == StFinish && out_free) begin
      out_word_q.accepted <= res_acc_q;
      out_word_q.status   <= res_status_q;
    end
    unique case (state_q)
      StIdle: begin
        thead_q <= in_word_i.head;
        tsym_q  <= in_word_i.symbol;
        tmask_rd_q <= tmask_mem[in_word_i.symbol];
        tvalid_rd_q <= tvalid_q[in_word_i.symbol];
        n_q <= wlen_next;
        i_q <= '0;
        res_acc_q <= 1'b0;
        if (wlen_q == LW'(MAX_WORD) || too_long_q) res_status_q <= StatusTooLong;
        else if (ovf_q) res_status_q <= StatusOverflow;
        else res_status_q <= StatusOk;
        if (in_acc) begin
          if (in_word_i.mode == ModeBinRule && rule_ok
              && rcount_q < RCW'(MAX_BINARY_RULES)) begin
            rule_mem[rcount_q[RAW-1:0]] <= {in_word_i.head, in_word_i.left_child,
                                            in_word_i.right_child};
          end
          if (in_word_i.mode == ModeSymbol && wlen_q < LW'(MAX_WORD)) begin
            word_mem[wlen_q[IW-1:0]] <= in_word_i.symbol;
          end
        end
      end
      StTerm: begin
        tmask_mem[tsym_q] <= (tvalid_rd_q ? tmask_rd_q : '0)
                           | (NONTERMS'(1) << thead_q[NTW-1:0]);
      end
      StDiagRd:  word_rd_q <= word_mem[i_q];
      StDiagSym: begin
        tmask_rd_q  <= tmask_mem[word_rd_q];
        tvalid_rd_q <= tvalid_q[word_rd_q];
      end
      StDiagWr: begin
        chart_mem[i_q][i_q] <= tvalid_rd_q ? tmask_rd_q : '0;
        if (LW'(i_q) == n_q - LW'(1)) begin
          i_q   <= '0;
          len_q <= LW'(2);
        end else begin
          i_q <= i_q + IW'(1);
        end
      end
      StCellStart: begin
        acc_q <= '0;
        p_q   <= i_q;
        r_q   <= '0;
      end
      StPairRd: begin
        left_rd_q  <= chart_mem[i_q][p_q];
        right_rd_q <= chart_mem[p1_c][j_c];
        r_q        <= '0;
      end
      StRuleRd: rule_rd_q <= rule_mem[r_q[RAW-1:0]];
      StRuleEv: begin
        acc_q <= acc_q | hit_c;
        if (r_q == rcount_q - RCW'(1)) p_q <= p1_c;
        else r_q <= r_q + RCW'(1);
      end
      StCellWr: begin
        chart_mem[i_q][j_c] <= acc_q;
        if (i_end_c == (LW + 1)'(n_q)) begin
          i_q   <= '0;
          len_q <= len_q + LW'(1);
        end else begin
          i_q <= i_q + IW'(1);
        end
      end
      StFinalRd: left_rd_q <= chart_mem[0][IW'(n_q - LW'(1))];
      StFinalEv: begin
        res_status_q <= StatusOk;
        if ({1'b0, start_q} < (NtIdxW + 1)'(NONTERMS)) res_acc_q <= left_rd_q[start_q[NTW-1:0]];
        else res_acc_q <= 1'b0;
      end
      StFinish: ;
      default: ;
    endcase
  end

endmodule
